[hw/rtl/lssbc_pkg.sv]
package lssbc_pkg;

    typedef logic [7:0] t_byte;

    localparam logic [63:0] KEY_MASK = 64'h2540_7dc1_f39b_e68a;
    localparam logic [31:0] LCG_MUL  = 32'h0003_43fd;
    localparam logic [31:0] LCG_ADD  = 32'h0026_9ec3;

    localparam int unsigned REG_KEY  = 0;
    localparam int unsigned REG_MODE = 1;

endpackage

[hw/rtl/lcg_shuffled_sbox_byte_cipher.sv]
// Byte stream cipher with a key-shuffled substitution table. Every accepted request carries
// one data byte and gives exactly one result byte, in order; the table read is registered
// in the lookup stage and the result in the output register. When the output is taken, one
// byte is accepted per cycle. After reset and after every configuration write, o_ready
// stays low while the forward and inverse tables are rebuilt in two single-port-write
// memories of 256 bytes: a start step, the load of the identity, then for each of the 256
// swaps a generator step, a read of both entries and one write for each entry, and then a
// read and a write for each of the 256 inverse entries. The swap writes are serial because
// the forward table has a single write port. The byte position runs modulo 256 and returns
// to zero after a byte marked last. Write configuration only while no request is in flight.
module lcg_shuffled_sbox_byte_cipher
    import lssbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_result_byte,
    output logic        o_result_last
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_W1   = 3'd4;
    localparam logic [2:0] ST_W2   = 3'd5;
    localparam logic [2:0] ST_IRD  = 3'd6;
    localparam logic [2:0] ST_IWR  = 3'd7;

    // config
    logic [63:0] r_key;
    logic        r_mode;
    logic        cfg_wr;

    // build control
    logic [2:0]  r_state, n_state;
    t_byte       r_idx, n_idx;
    logic [31:0] r_seed, n_seed;
    logic        r_tbl_ok, n_tbl_ok;

    logic [63:0] mkey;
    logic [31:0] seed_init;

    // memories
    t_byte r_fwd_mem [256];
    t_byte r_inv_mem [256];
    t_byte r_rd_a, r_rd_b, r_rd_inv;
    logic  fwd_we, fwd_re_a, fwd_re_b, inv_we;
    t_byte fwd_wa, fwd_wd, fwd_ra_a, fwd_ra_b, inv_wa, inv_wd;

    // datapath
    logic  accept, out_free, lk_free;
    t_byte r_pos;
    t_byte m_byte, lk_addr;
    logic  r_lk_vld, r_lk_dec, r_lk_last;
    t_byte r_lk_mask;
    logic  r_out_vld;
    t_byte r_out_byte;
    logic  r_out_last;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[3] == 1'(REG_MODE)) ? {63'd0, r_mode} : r_key;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= 64'd0;
            r_mode <= 1'b1;
        end else if (cfg_wr) begin
            if (paddr[3] == 1'(REG_KEY)) begin
                r_key <= pwdata;
            end else begin
                r_mode <= pwdata[0];
            end
        end
    end

    assign mkey      = r_key ^ KEY_MASK;
    assign seed_init = {mkey[7:0], mkey[15:8], mkey[23:16], mkey[31:24]}
                     ^ {mkey[39:32], mkey[47:40], mkey[55:48], mkey[63:56]};

    assign out_free = !r_out_vld || i_ready;
    assign lk_free  = !r_lk_vld || out_free;
    assign o_ready  = r_tbl_ok && lk_free;
    assign accept   = i_valid && o_ready;

    assign m_byte  = mkey[{r_pos[2:0], 3'b000} +: 8];
    assign lk_addr = r_mode ? (i_data_byte ^ r_pos ^ m_byte) : (i_data_byte ^ m_byte);

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_seed   = r_seed;
        n_tbl_ok = r_tbl_ok;
        fwd_we   = 1'b0;
        fwd_wa   = r_idx;
        fwd_wd   = r_idx;
        fwd_re_a = accept;
        fwd_ra_a = lk_addr;
        fwd_re_b = 1'b0;
        fwd_ra_b = r_seed[23:16];
        inv_we   = 1'b0;
        inv_wa   = r_rd_a;
        inv_wd   = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (!r_tbl_ok) begin
                    n_seed  = seed_init;
                    n_idx   = 8'd0;
                    n_state = ST_INIT;
                end
            end
            ST_INIT: begin
                fwd_we = 1'b1;
                n_idx  = r_idx + 8'd1;
                if (r_idx == 8'hff) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_seed  = 32'(r_seed * LCG_MUL) + LCG_ADD;
                n_state = ST_RD;
            end
            ST_RD: begin
                fwd_re_a = 1'b1;
                fwd_ra_a = r_idx;
                fwd_re_b = 1'b1;
                n_state  = ST_W1;
            end
            ST_W1: begin
                fwd_we  = 1'b1;
                fwd_wd  = r_rd_b;
                n_state = ST_W2;
            end
            ST_W2: begin
                fwd_we  = 1'b1;
                fwd_wa  = r_seed[23:16];
                fwd_wd  = r_rd_a;
                n_idx   = r_idx + 8'd1;
                n_state = (r_idx == 8'hff) ? ST_IRD : ST_MUL;
            end
            ST_IRD: begin
                fwd_re_a = 1'b1;
                fwd_ra_a = r_idx;
                n_state  = ST_IWR;
            end
            ST_IWR: begin
                inv_we = 1'b1;
                n_idx  = r_idx + 8'd1;
                if (r_idx == 8'hff) begin
                    n_state  = ST_IDLE;
                    n_tbl_ok = 1'b1;
                end else begin
                    n_state = ST_IRD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // a config write restarts any build
        if (cfg_wr) begin
            n_state  = ST_IDLE;
            n_tbl_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= 8'd0;
            r_seed   <= 32'd0;
            r_tbl_ok <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_seed   <= n_seed;
            r_tbl_ok <= n_tbl_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fwd_we) begin
            r_fwd_mem[fwd_wa] <= fwd_wd;
        end
        if (fwd_re_a) begin
            r_rd_a <= r_fwd_mem[fwd_ra_a];
        end
        if (fwd_re_b) begin
            r_rd_b <= r_fwd_mem[fwd_ra_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (inv_we) begin
            r_inv_mem[inv_wa] <= inv_wd;
        end
        if (accept) begin
            r_rd_inv <= r_inv_mem[lk_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 8'd0;
            r_lk_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_pos <= i_end_of_message ? 8'd0 : r_pos + 8'd1;
            end
            if (lk_free) begin
                r_lk_vld <= accept;
            end
            if (out_free) begin
                r_out_vld <= r_lk_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lk_dec  <= !r_mode;
            r_lk_last <= i_end_of_message;
            r_lk_mask <= r_mode ? m_byte : (m_byte ^ r_pos);
        end
        if (r_lk_vld && out_free) begin
            r_out_byte <= (r_lk_dec ? r_rd_inv : r_rd_a) ^ r_lk_mask;
            r_out_last <= r_lk_last;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_result_byte = r_out_byte;
    assign o_result_last = r_out_last;

endmodule

[test/cipher_checker.sv]
module cipher_checker
    import lssbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_message,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [7:0]  o_result_byte,
    input  logic        o_result_last,
    output int          o_mismatches,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] KEY_ADDR  = 4'(REG_KEY * 8);
    localparam logic [3:0] MODE_ADDR = 4'(REG_MODE * 8);

    typedef struct packed {
        t_byte res_byte;
        logic  res_last;
    } t_cipher_out;

    t_cipher_out expected_q[$];

    logic [63:0] cfg_key;
    logic        cfg_encrypt;
    t_byte       msg_pos;
    t_byte       fwd_table [256];
    t_byte       inv_table [256];
    int          mismatch_total = 0;

    function automatic t_byte key_byte(input logic [2:0] j);
        return cfg_key[8*j +: 8] ^ KEY_MASK[8*j +: 8];
    endfunction

    // Shuffle the identity with the key-seeded generator, then invert it
    task automatic rebuild_tables();
        logic [31:0] seed;
        t_byte       pick;
        t_byte       held;
        seed = {key_byte(3'd0), key_byte(3'd1), key_byte(3'd2), key_byte(3'd3)}
             ^ {key_byte(3'd4), key_byte(3'd5), key_byte(3'd6), key_byte(3'd7)};
        for (int i = 0; i < 256; i++) fwd_table[i] = t_byte'(i);
        for (int i = 0; i < 256; i++) begin
            seed = seed * LCG_MUL + LCG_ADD;
            pick = seed[23:16];
            held = fwd_table[i];
            fwd_table[i] = fwd_table[pick];
            fwd_table[pick] = held;
        end
        for (int i = 0; i < 256; i++) inv_table[fwd_table[i]] = t_byte'(i);
    endtask

    function automatic t_byte transform_byte(input t_byte d);
        t_byte m;
        m = key_byte(msg_pos[2:0]);
        if (cfg_encrypt) return fwd_table[d ^ msg_pos ^ m] ^ m;
        return inv_table[d ^ m] ^ m ^ msg_pos;
    endfunction

    always @(posedge i_clk) begin
        t_cipher_out want;
        if (!i_rst_n) begin
            cfg_key     = '0;
            cfg_encrypt = 1'b1;
            msg_pos     = '0;
            expected_q.delete();
            rebuild_tables();
        end else begin
            if (o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual byte %02h last %0b",
                             $time, o_result_byte, o_result_last);
                    mismatch_total++;
                end else begin
                    want = expected_q.pop_front();
                    if (o_result_byte !== want.res_byte) begin
                        $display("%0t: result_byte expected %02h actual %02h",
                                 $time, want.res_byte, o_result_byte);
                        mismatch_total++;
                    end
                    if (o_result_last !== want.res_last) begin
                        $display("%0t: result_last expected %0b actual %0b",
                                 $time, want.res_last, o_result_last);
                        mismatch_total++;
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    KEY_ADDR: begin
                        cfg_key = pwdata;
                        rebuild_tables();
                    end
                    MODE_ADDR: cfg_encrypt = pwdata[0];
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                want.res_byte = transform_byte(i_data_byte);
                want.res_last = i_end_of_message;
                expected_q.push_back(want);
                msg_pos = i_end_of_message ? t_byte'(0) : msg_pos + 8'd1;
            end
        end
        o_pending    <= expected_q.size();
        o_mismatches <= mismatch_total;
    end

endmodule

[test/tb_lcg_shuffled_sbox_byte_cipher.sv]
module tb_lcg_shuffled_sbox_byte_cipher
    import lssbc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [3:0] KEY_ADDR  = 4'(REG_KEY * 8);
    localparam logic [3:0] MODE_ADDR = 4'(REG_MODE * 8);

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        psel             = 1'b0;
    logic        penable          = 1'b0;
    logic        pwrite           = 1'b0;
    logic [3:0]  paddr            = '0;
    logic [63:0] pwdata           = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        i_valid          = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte      = '0;
    logic        i_end_of_message = 1'b0;
    logic        o_valid;
    logic        i_ready          = 1'b0;
    logic [7:0]  o_result_byte;
    logic        o_result_last;

    int mismatches;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit drain_fail    = 1'b0;

    always #2 i_clk = ~i_clk;

    lcg_shuffled_sbox_byte_cipher uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_byte    (o_result_byte),
        .o_result_last    (o_result_last)
    );

    cipher_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_byte    (o_result_byte),
        .o_result_last    (o_result_last),
        .o_mismatches     (mismatches),
        .o_pending        (pending)
    );

    always @(negedge i_clk) i_ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic push_byte(input t_byte d, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_data_byte      <= d;
        i_end_of_message <= last;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) push_byte(t_byte'($urandom), i == len - 1);
    endtask

    // table rebuild follows every write, so hold off until the block is ready again
    task automatic reg_write(input logic [3:0] addr, input logic [63:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic write_mode(input logic encrypt);
        logic [63:0] v;
        v    = {$urandom, $urandom};
        v[0] = encrypt;
        reg_write(MODE_ADDR, v);
    endtask

    task automatic drain_results();
        int waited;
        @(negedge i_clk);
        i_valid <= 1'b0;
        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending != 0) drain_fail = 1'b1;
    endtask

    initial begin
        logic [63:0] key_val;
        int          sent;
        int          len;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: zero key, encrypt
        send_idle_pct = 11;
        recv_idle_pct = 52;
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b0);
        push_byte(8'h55, 1'b0);
        push_byte(8'haa, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hfe, 1'b0);
        push_byte(8'h7f, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hff, 1'b1);
        push_byte(8'hff, 1'b1);
        push_byte(8'h00, 1'b1);
        for (int i = 0; i < 8; i++) push_byte(t_byte'(i * 8'h23), i == 7);

        for (int ph = 0; ph < 8; ph++) begin
            drain_results();
            case (ph)
                0:       key_val = '0;
                1:       key_val = '1;
                2:       key_val = KEY_MASK;
                default: key_val = {$urandom, $urandom};
            endcase
            if (ph < 3) begin
                send_idle_pct = 11;
                recv_idle_pct = 52;
            end else if (ph < 6) begin
                send_idle_pct = 52;
                recv_idle_pct = 11;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 4) begin
                write_mode(ph[0]);
                reg_write(KEY_ADDR, key_val);
            end else begin
                reg_write(KEY_ADDR, key_val);
                write_mode(ph[0]);
            end
            sent = 0;
            if (ph == 2 || ph == 6) begin
                len = $urandom_range(257, 300);
                send_message(len);
                sent += len;
            end
            while (sent < 55) begin
                len = $urandom_range(1, 24);
                send_message(len);
                sent += len;
            end
            // leave a message open across the next write
            if (ph[0]) repeat ($urandom_range(1, 9)) push_byte(t_byte'($urandom), 1'b0);
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && !drain_fail) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[lcg_shuffled_sbox_byte_cipher.f]
hw/rtl/lssbc_pkg.sv
hw/rtl/lcg_shuffled_sbox_byte_cipher.sv
test/cipher_checker.sv
test/tb_lcg_shuffled_sbox_byte_cipher.sv
